// ===== src/m3i_pkg.sv =====
// ----------------------------------------------------------------------------
// m3i_pkg: shared constants for the 3x3 matrix inverse
// Default entry format and the depth of the queue between front and back.
// ----------------------------------------------------------------------------
package m3i_pkg;

    localparam int ENTRY_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Queue between the front and back parts; depth is a power of two
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

endpackage

// ===== src/matrix3_inverse.sv =====
// ----------------------------------------------------------------------------
// matrix3_inverse: 3x3 matrix inverse by the adjugate, signed fixed point
// Exact determinant and cofactors, nine pipelined divisions, truncate toward
// zero and saturate to the entry format; singular input gives all zeros.
//
//   channel  signals                         direction  word
//   in       in_valid, in_ready, a00..a22    into       one matrix
//   out      out_valid, out_ready, b00..b22, out of     inverse, det, flag
//            det_out, singular
//
// One matrix enters per cycle and one result leaves per cycle when out_ready
// stays high. A matrix passes through four front stages for products and the
// determinant, the queue write, then stage 0, the overflow check, one stage
// per quotient bit and the output register in the divider pipe.
// Reset clears all valid flags and queue counters; payload is not reset.
// The front never stalls: in_ready is a credit on the 8-word queue. A stalled
// output freezes the divider pipe while the front keeps filling the queue.
// ----------------------------------------------------------------------------
module matrix3_inverse
    import m3i_pkg::*;
#(
    parameter int ENTRY_BITS = ENTRY_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [ENTRY_BITS-1:0] a00,
    input  logic signed [ENTRY_BITS-1:0] a01,
    input  logic signed [ENTRY_BITS-1:0] a02,
    input  logic signed [ENTRY_BITS-1:0] a10,
    input  logic signed [ENTRY_BITS-1:0] a11,
    input  logic signed [ENTRY_BITS-1:0] a12,
    input  logic signed [ENTRY_BITS-1:0] a20,
    input  logic signed [ENTRY_BITS-1:0] a21,
    input  logic signed [ENTRY_BITS-1:0] a22,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [ENTRY_BITS-1:0] b00,
    output logic signed [ENTRY_BITS-1:0] b01,
    output logic signed [ENTRY_BITS-1:0] b02,
    output logic signed [ENTRY_BITS-1:0] b10,
    output logic signed [ENTRY_BITS-1:0] b11,
    output logic signed [ENTRY_BITS-1:0] b12,
    output logic signed [ENTRY_BITS-1:0] b20,
    output logic signed [ENTRY_BITS-1:0] b21,
    output logic signed [ENTRY_BITS-1:0] b22,
    output logic signed [ENTRY_BITS-1:0] det_out,
    output logic                         singular
);

    localparam int CW = 2 * ENTRY_BITS + 1;
    localparam int DW = 3 * ENTRY_BITS + 2;
    localparam int QW = 9 * CW + DW;

    logic [8:0][ENTRY_BITS-1:0] a_w;
    logic [8:0][ENTRY_BITS-1:0] b_w;
    logic                       in_take;
    logic                       push;
    logic [QW-1:0]              push_word;
    logic                       q_valid;
    logic [QW-1:0]              q_word;
    logic                       q_pop;

    // Gather the matrix row by row
    assign a_w[0] = a00;
    assign a_w[1] = a01;
    assign a_w[2] = a02;
    assign a_w[3] = a10;
    assign a_w[4] = a11;
    assign a_w[5] = a12;
    assign a_w[6] = a20;
    assign a_w[7] = a21;
    assign a_w[8] = a22;

    assign in_take = in_valid && in_ready;

    m3i_front #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .a         (a_w),
        .push      (push),
        .push_word (push_word)
    );

    // Credit covers words in the front pipe plus words held in the queue
    m3i_queue #(
        .QW (QW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_take   (in_take),
        .room      (in_ready),
        .push      (push),
        .push_word (push_word),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_word    (q_word)
    );

    m3i_back #(
        .ENTRY_BITS (ENTRY_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .b         (b_w),
        .det_out   (det_out),
        .singular  (singular)
    );

    // Scatter the inverse back to row-major ports
    assign b00 = b_w[0];
    assign b01 = b_w[1];
    assign b02 = b_w[2];
    assign b10 = b_w[3];
    assign b11 = b_w[4];
    assign b12 = b_w[5];
    assign b20 = b_w[6];
    assign b21 = b_w[7];
    assign b22 = b_w[8];

endmodule

// ===== src/m3i_front.sv =====
// ----------------------------------------------------------------------------
// m3i_front: cofactor and determinant pipeline
// Four stages with no stall: pair products, cofactors, split determinant
// products, determinant sum. Emits one packed word per matrix.
// ----------------------------------------------------------------------------
module m3i_front
    import m3i_pkg::*;
#(
    parameter int ENTRY_BITS = ENTRY_BITS_DEF,
    localparam int E  = ENTRY_BITS,
    localparam int CW = 2 * E + 1,
    localparam int DW = 3 * E + 2,
    localparam int QW = 9 * CW + DW
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_take,
    input  logic [8:0][E-1:0]    a,
    output logic                 push,
    output logic [QW-1:0]        push_word
);

    localparam int PW  = 2 * E;
    localparam int PPW = 2 * E + 1;

    logic [3:0]           v_reg;
    logic signed [PW-1:0] pa_reg  [9];
    logic signed [PW-1:0] pb_reg  [9];
    logic signed [E-1:0]  e1_reg  [3];
    logic signed [E-1:0]  e2_reg  [3];
    logic signed [CW-1:0] cof2_reg [9];
    logic signed [CW-1:0] cof3_reg [9];
    logic signed [CW-1:0] cof4_reg [9];
    logic signed [PPW-1:0] plo_reg [3];
    logic signed [PPW-1:0] phi_reg [3];
    logic [DW-1:0]        det_reg;
    logic [DW-1:0]        det_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], in_take};
        end
    end

    // Stage 1 and 2: the two products of each 2x2 minor, then their difference
    for (genvar l = 0; l < 9; l++)
    begin : g_minor
        localparam int R  = l / 3;
        localparam int C  = l % 3;
        localparam int C1 = (C + 1) % 3;
        localparam int C2 = (C + 2) % 3;
        localparam int U  = (R + 1) % 3;
        localparam int V  = (R + 2) % 3;

        always_ff @(posedge clk)
        begin
            pa_reg[l]   <= $signed(a[C1 * 3 + U]) * $signed(a[C2 * 3 + V]);
            pb_reg[l]   <= $signed(a[C2 * 3 + U]) * $signed(a[C1 * 3 + V]);
            cof2_reg[l] <= pa_reg[l] - pb_reg[l];
            cof3_reg[l] <= cof2_reg[l];
            cof4_reg[l] <= cof3_reg[l];
        end

        assign push_word[l * CW +: CW] = cof4_reg[l];
    end

    // Stage 3: determinant expands along row 2; cofactor split into halves
    for (genvar r = 0; r < 3; r++)
    begin : g_det
        always_ff @(posedge clk)
        begin
            e1_reg[r]  <= $signed(a[6 + r]);
            e2_reg[r]  <= e1_reg[r];
            plo_reg[r] <= $signed({1'b0, cof2_reg[r * 3 + 2][E-1:0]}) * e2_reg[r];
            phi_reg[r] <= $signed(cof2_reg[r * 3 + 2][CW-1:E]) * e2_reg[r];
        end
    end

    // Stage 4: recombine halves and sum
    always_comb
    begin
        det_next = '0;
        for (int r = 0; r < 3; r++)
        begin
            det_next = det_next
                + ({{(DW - PPW){phi_reg[r][PPW-1]}}, phi_reg[r]} << E)
                + {{(DW - PPW){plo_reg[r][PPW-1]}}, plo_reg[r]};
        end
    end

    always_ff @(posedge clk)
    begin
        det_reg <= det_next;
    end

    assign push_word[9 * CW +: DW] = det_reg;
    assign push                    = v_reg[3];

endmodule

// ===== src/m3i_queue.sv =====
// ----------------------------------------------------------------------------
// m3i_queue: decoupling queue between front and back
// Holds finished front words; grants input room by credit so the front
// pipeline never has to stall.
// ----------------------------------------------------------------------------
module m3i_queue
    import m3i_pkg::*;
#(
    parameter int QW = 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_take,
    output logic          room,
    input  logic          push,
    input  logic [QW-1:0] push_word,
    input  logic          pop,
    output logic          q_valid,
    output logic [QW-1:0] q_word
);

    logic [QW-1:0]       mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_reg;
    logic [QUEUE_AW-1:0] rd_reg;
    logic [QUEUE_CW-1:0] fill_reg;
    logic [QUEUE_CW-1:0] fill_next;
    logic [QUEUE_CW-1:0] occ_reg;
    logic [QUEUE_CW-1:0] occ_next;

    // occ counts words accepted at the input and not yet popped
    always_comb
    begin
        occ_next  = occ_reg + QUEUE_CW'(in_take) - QUEUE_CW'(pop);
        fill_next = fill_reg + QUEUE_CW'(push) - QUEUE_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
            occ_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            fill_reg <= fill_next;
            occ_reg  <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_word;
        end
    end

    assign q_word  = mem[rd_reg];
    assign q_valid = (fill_reg != '0);
    assign room    = (occ_reg < QUEUE_CW'(QUEUE_DEPTH));

    a_fill_le_occ: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= occ_reg)
        else $error("queue holds more words than were credited");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (fill_reg < QUEUE_CW'(QUEUE_DEPTH)) || pop)
        else $error("push into full queue");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("pop from empty queue");

endmodule

// ===== src/m3i_back.sv =====
// ----------------------------------------------------------------------------
// m3i_back: pipelined divider and saturation
// Restoring division, one quotient bit per stage for all nine entries at
// once, behind an overflow check; ends in the output register.
// ----------------------------------------------------------------------------
module m3i_back
    import m3i_pkg::*;
#(
    parameter int ENTRY_BITS = ENTRY_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int E  = ENTRY_BITS,
    localparam int CW = 2 * E + 1,
    localparam int DW = 3 * E + 2,
    localparam int QW = 9 * CW + DW
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  logic [QW-1:0]     q_word,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [8:0][E-1:0] b,
    output logic [E-1:0]      det_out,
    output logic              singular
);

    localparam int RW  = CW + 2 * FRAC_BITS;
    localparam int SW0 = (RW > DW + E) ? RW : DW + E;
    localparam int SW  = SW0 + 1;
    localparam int NS  = E + 3;
    localparam logic [E-1:0] LIM_POS = {1'b0, {(E - 1){1'b1}}};
    localparam logic [E-1:0] LIM_NEG = {1'b1, {(E - 1){1'b0}}};

    logic [NS-1:0] vld_reg;
    logic          en;

    // stage 0
    logic [DW-1:0] det_w;
    logic [DW-1:0] dmag_w;
    logic [DW-1:0] dshr_w;
    logic [E-1:0]  dlim_w;
    logic [E-1:0]  dmsat_w;
    logic [E-1:0]  dsat_w;
    logic [DW-1:0] d0_reg;
    logic [RW-1:0] n0_reg [9];
    logic [8:0]    neg0_reg;
    logic          sing0_reg;
    logic [E-1:0]  dsat0_reg;

    // stage 1
    logic [RW-1:0] r1_reg [9];
    logic [DW-1:0] d1_reg;
    logic [8:0]    ovf1_reg;
    logic [8:0]    neg1_reg;
    logic          sing1_reg;
    logic [E-1:0]  dsat1_reg;

    // division steps
    logic [RW-1:0] r_reg    [E][9];
    logic [DW-1:0] d_reg    [E];
    logic [E-1:0]  q_reg    [E][9];
    logic [8:0]    ovf_reg  [E];
    logic [8:0]    neg_reg  [E];
    logic          sing_reg [E];
    logic [E-1:0]  dsat_reg [E];

    // output
    logic [8:0][E-1:0] b_next;
    logic [8:0][E-1:0] b_reg;
    logic [E-1:0]      det_out_reg;
    logic              singular_reg;

    // Advance the whole pipe unless the output word is stuck
    assign en    = !vld_reg[NS-1] || out_ready;
    assign q_pop = en && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], q_valid};
        end
    end

    // Stage 0: magnitudes, signs, determinant output
    assign det_w = q_word[9 * CW +: DW];

    always_comb
    begin
        dmag_w = det_w[DW-1] ? -det_w : det_w;
        dshr_w = dmag_w >> (2 * FRAC_BITS);
        dlim_w = det_w[DW-1] ? LIM_NEG : LIM_POS;
        if (dshr_w > DW'(dlim_w))
        begin
            dmsat_w = dlim_w;
        end
        else
        begin
            dmsat_w = dshr_w[E-1:0];
        end
        dsat_w = det_w[DW-1] ? -dmsat_w : dmsat_w;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d0_reg    <= dmag_w;
            sing0_reg <= (det_w == '0);
            dsat0_reg <= dsat_w;
        end
    end

    for (genvar l = 0; l < 9; l++)
    begin : g_lane0
        logic [CW-1:0] c_w;
        logic [CW-1:0] cm_w;

        assign c_w  = q_word[l * CW +: CW];
        assign cm_w = c_w[CW-1] ? -c_w : c_w;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n0_reg[l]   <= RW'(cm_w) << (2 * FRAC_BITS);
                neg0_reg[l] <= c_w[CW-1] ^ det_w[DW-1];
            end
        end
    end

    // Stage 1: quotient at or above 2^E saturates
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 9; l++)
            begin
                r1_reg[l]   <= n0_reg[l];
                ovf1_reg[l] <= SW'(n0_reg[l]) >= (SW'(d0_reg) << E);
            end
            d1_reg    <= d0_reg;
            neg1_reg  <= neg0_reg;
            sing1_reg <= sing0_reg;
            dsat1_reg <= dsat0_reg;
        end
    end

    // Restoring steps, most significant quotient bit first
    for (genvar j = 0; j < E; j++)
    begin : g_step
        localparam int K = E - 1 - j;

        logic [RW-1:0] r_in [9];
        logic [E-1:0]  q_in [9];
        logic [DW-1:0] d_in;
        logic [8:0]    ovf_in;
        logic [8:0]    neg_in;
        logic          sing_in;
        logic [E-1:0]  dsat_in;
        logic [8:0]    ge_w;
        logic [RW-1:0] rn_w [9];

        if (j == 0)
        begin : g_first
            always_comb
            begin
                for (int l = 0; l < 9; l++)
                begin
                    r_in[l] = r1_reg[l];
                    q_in[l] = '0;
                end
                d_in    = d1_reg;
                ovf_in  = ovf1_reg;
                neg_in  = neg1_reg;
                sing_in = sing1_reg;
                dsat_in = dsat1_reg;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                for (int l = 0; l < 9; l++)
                begin
                    r_in[l] = r_reg[j-1][l];
                    q_in[l] = q_reg[j-1][l];
                end
                d_in    = d_reg[j-1];
                ovf_in  = ovf_reg[j-1];
                neg_in  = neg_reg[j-1];
                sing_in = sing_reg[j-1];
                dsat_in = dsat_reg[j-1];
            end
        end

        always_comb
        begin
            for (int l = 0; l < 9; l++)
            begin
                ge_w[l] = SW'(r_in[l]) >= (SW'(d_in) << K);
                rn_w[l] = RW'(SW'(r_in[l]) - (SW'(d_in) << K));
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 9; l++)
                begin
                    r_reg[j][l] <= ge_w[l] ? rn_w[l] : r_in[l];
                    q_reg[j][l] <= {q_in[l][E-2:0], ge_w[l]};
                end
                d_reg[j]    <= d_in;
                ovf_reg[j]  <= ovf_in;
                neg_reg[j]  <= neg_in;
                sing_reg[j] <= sing_in;
                dsat_reg[j] <= dsat_in;
            end
        end
    end

    // Output: clamp, apply sign, zero on singular
    always_comb
    begin
        logic [E-1:0] lim;
        logic [E-1:0] mag;
        for (int l = 0; l < 9; l++)
        begin
            lim = neg_reg[E-1][l] ? LIM_NEG : LIM_POS;
            if (ovf_reg[E-1][l] || (q_reg[E-1][l] > lim))
            begin
                mag = lim;
            end
            else
            begin
                mag = q_reg[E-1][l];
            end
            if (sing_reg[E-1])
            begin
                b_next[l] = '0;
            end
            else
            begin
                b_next[l] = neg_reg[E-1][l] ? -mag : mag;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_reg        <= b_next;
            det_out_reg  <= sing_reg[E-1] ? '0 : dsat_reg[E-1];
            singular_reg <= sing_reg[E-1];
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign b         = b_reg;
    assign det_out   = det_out_reg;
    assign singular  = singular_reg;

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipe moved while stalled");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && singular) |-> (b_reg == '0) && (det_out_reg == '0))
        else $error("singular word carries nonzero data");

    a_pop_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> vld_reg[0])
        else $error("popped word lost at stage 0");

endmodule
